FILE: rtl/cwfp_pkg.sv
// Shared types, constants and register map for the CRC-checked word frame parser.
package cwfp_pkg;

	localparam int VALUES_PER_FRAME_DEF = 3;

	localparam int CFG_ADDR_W = 3;
	localparam logic CFG_IDX_POLY = 1'b0;
	localparam logic CFG_IDX_INIT = 1'b1;

	localparam logic [7:0] CRC_POLY_RST = 8'h31;
	localparam logic [7:0] CRC_INIT_RST = 8'hFF;

	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_CRC_ERR = 1'b1;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
	} cwfp_in_t;

	typedef struct packed {
		logic [1:0]  value_index;
		logic [31:0] value_bits;
		logic        status;
		logic [2:0]  failed_word;
		logic        frame_last;
	} cwfp_out_t;

	// Parser result toward the output queue
	typedef struct packed {
		logic      valid;
		cwfp_out_t item;
	} cwfp_res_t;

	// Register file toward the parser
	typedef struct packed {
		logic [7:0] crc_polynomial;
		logic [7:0] crc_initial;
		logic       wr;
	} cwfp_cfg_t;

endpackage

FILE: rtl/cwfp_crc8.sv
// One byte of MSB-first CRC-8, unrolled over the eight bit steps.
module cwfp_crc8 import cwfp_pkg::*; (
	input  logic [7:0] crc_in,
	input  logic [7:0] data,
	input  logic [7:0] poly,
	output logic [7:0] crc_out
);

	logic [7:0] c;

	always_comb begin
		c = crc_in ^ data;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ poly;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		crc_out = c;
	end

endmodule

FILE: rtl/cwfp_cfg_regs.sv
// APB register file: CRC polynomial and CRC initial value.
module cwfp_cfg_regs import cwfp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	output cwfp_cfg_t             cfg
);

	logic [7:0] poly_q;
	logic [7:0] init_q;
	logic       wr_en;
	logic       idx;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= CRC_POLY_RST;
			init_q <= CRC_INIT_RST;
		end else if (wr_en) begin
			unique case (idx)
				CFG_IDX_POLY: poly_q <= pwdata[7:0];
				CFG_IDX_INIT: init_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			CFG_IDX_POLY: prdata = {24'd0, poly_q};
			CFG_IDX_INIT: prdata = {24'd0, init_q};
			default:      prdata = '0;
		endcase
	end

	assign cfg.crc_polynomial = poly_q;
	assign cfg.crc_initial = init_q;
	assign cfg.wr = wr_en;

endmodule

FILE: rtl/cwfp_parser.sv
// Byte phase tracking, running CRC, word pairing and result formation.
module cwfp_parser import cwfp_pkg::*; #(
	parameter int VALUES_PER_FRAME = VALUES_PER_FRAME_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      accept,
	input  cwfp_in_t  in_item,
	input  cwfp_cfg_t cfg,
	output logic      busy,
	output cwfp_res_t res
);

	localparam int WORDS = 2 * VALUES_PER_FRAME;
	localparam int WCW = $clog2(WORDS + 1);
	localparam logic [WCW-1:0] WORDS_W = WCW'(WORDS);

	typedef enum logic [1:0] {
		PH_HIGH,
		PH_LOW,
		PH_CRC
	} phase_t;

	typedef enum logic [1:0] {
		RC_IDLE,
		RC_LOW,
		RC_HIGH
	} rc_t;

	phase_t         phase_q, phase_eff;
	rc_t            rc_q;
	logic [WCW-1:0] wc_q, wc_eff, wc_inc;
	logic           done_q, done_eff;
	logic [7:0]     held_hi_q, held_lo_q, crc_q;
	logic [15:0]    upper_q;
	logic [7:0]     crc_src, crc_dat, crc_nxt;
	logic [WCW+2:0] wc_ext;
	logic           crc_ok;

	assign phase_eff = in_item.frame_start ? PH_HIGH : phase_q;
	assign wc_eff = in_item.frame_start ? '0 : wc_q;
	assign done_eff = in_item.frame_start ? 1'b0 : done_q;
	assign wc_inc = wc_eff + 1'b1;
	assign wc_ext = {3'd0, wc_eff};
	assign crc_ok = (crc_q == in_item.rx_byte);
	assign busy = (rc_q != RC_IDLE);

	// Shared CRC step: normal bytes, or rebuilding the running CRC after a config write
	always_comb begin
		unique case (rc_q)
			RC_HIGH: begin
				crc_src = cfg.crc_initial;
				crc_dat = held_hi_q;
			end
			RC_LOW: begin
				crc_src = crc_q;
				crc_dat = held_lo_q;
			end
			default: begin
				crc_src = (phase_eff == PH_HIGH) ? cfg.crc_initial : crc_q;
				crc_dat = in_item.rx_byte;
			end
		endcase
	end

	cwfp_crc8 u_crc (
		.crc_in  (crc_src),
		.data    (crc_dat),
		.poly    (cfg.crc_polynomial),
		.crc_out (crc_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HIGH;
			wc_q <= '0;
			done_q <= 1'b0;
			rc_q <= RC_IDLE;
			res <= '0;
		end else begin
			res.valid <= 1'b0;
			if (cfg.wr) begin
				rc_q <= RC_HIGH;
			end else begin
				unique case (rc_q)
					RC_HIGH: rc_q <= RC_LOW;
					RC_LOW:  rc_q <= RC_IDLE;
					default: rc_q <= RC_IDLE;
				endcase
			end
			if (accept) begin
				phase_q <= phase_eff;
				wc_q <= wc_eff;
				done_q <= done_eff;
				if (!done_eff) begin
					unique case (phase_eff)
						PH_HIGH: phase_q <= PH_LOW;
						PH_LOW:  phase_q <= PH_CRC;
						default: begin
							phase_q <= PH_HIGH;
							res.item.value_index <= wc_ext[2:1];
							if (!crc_ok) begin
								done_q <= 1'b1;
								res.valid <= 1'b1;
								res.item.value_bits <= '0;
								res.item.status <= STATUS_CRC_ERR;
								res.item.failed_word <= wc_ext[2:0];
								res.item.frame_last <= 1'b1;
							end else begin
								wc_q <= wc_inc;
								if (wc_eff[0]) begin
									res.valid <= 1'b1;
									res.item.value_bits <= {upper_q, held_hi_q, held_lo_q};
									res.item.status <= STATUS_OK;
									res.item.failed_word <= '0;
									res.item.frame_last <= (wc_inc >= WORDS_W);
									done_q <= (wc_inc >= WORDS_W);
								end
							end
						end
					endcase
				end
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (rc_q == RC_HIGH) begin
			crc_q <= crc_nxt;
		end else if (rc_q == RC_LOW) begin
			if (phase_q == PH_CRC) begin
				crc_q <= crc_nxt;
			end
		end else if (accept && !done_eff) begin
			unique case (phase_eff)
				PH_HIGH: begin
					held_hi_q <= in_item.rx_byte;
					crc_q <= crc_nxt;
				end
				PH_LOW: begin
					held_lo_q <= in_item.rx_byte;
					crc_q <= crc_nxt;
				end
				default: begin
					if (crc_ok && !wc_eff[0]) begin
						upper_q <= {held_hi_q, held_lo_q};
					end
				end
			endcase
		end
	end

endmodule

FILE: rtl/cwfp_out_q.sv
// Two-entry result queue between the parser and the output channel.
module cwfp_out_q import cwfp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cwfp_res_t res,
	output logic      full,
	output logic      out_valid,
	input  logic      out_ready,
	output cwfp_out_t out_data
);

	cwfp_out_t  mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign push = res.valid;
	assign pop = out_valid && out_ready;
	assign out_valid = (cnt_q != 2'd0);
	assign full = (cnt_q == 2'd2);
	assign out_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= res.item;
		end
	end

endmodule

FILE: rtl/crc_checked_word_frame_parser.sv
// Top level: CRC-checked 16-bit word response frame parser.
//
//   channel | direction | handshake         | payload
//   in      | input     | in_valid/in_ready | cwfp_in_t  (rx_byte, frame_start)
//   out     | output    | out_valid/out_ready | cwfp_out_t (value_index .. frame_last)
//   cfg     | input     | APB psel/penable  | crc_polynomial, crc_initial
//
// One byte is taken per cycle when in_ready is high; a CRC byte's result is registered, then queued.
// The running CRC advances one byte per accepted data byte through a single CRC-8 step.
// A config write holds in_ready low in states RC_HIGH and RC_LOW while the CRC of held bytes is redone.
// A two-entry result queue keeps input flowing while out_ready is low; the queue stalls input
// only when both entries are taken. Reset restores the register defaults and a clear frame.
module crc_checked_word_frame_parser import cwfp_pkg::*; #(
	parameter int VALUES_PER_FRAME = VALUES_PER_FRAME_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  cwfp_in_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output cwfp_out_t             out_data,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	cwfp_cfg_t cfg;
	cwfp_res_t res;
	logic      busy, full, accept;

	assign in_ready = !busy && !full;
	assign accept = in_valid && in_ready;

	cwfp_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cwfp_parser #(
		.VALUES_PER_FRAME (VALUES_PER_FRAME)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_item (in_data),
		.cfg     (cfg),
		.busy    (busy),
		.res     (res)
	);

	cwfp_out_q u_out_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.full      (full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == STATUS_CRC_ERR) |->
			(out_data.value_bits == 32'd0) && out_data.frame_last)
		else $error("error item with nonzero value or without frame_last");

	a_ok_no_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == STATUS_OK) |-> (out_data.failed_word == 3'd0))
		else $error("good item names a failed word");

	a_cfg_stall: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite |=> !in_ready)
		else $error("input taken while CRC is rebuilt after a config write");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> $past(!full))
		else $error("result pushed into a full queue");

endmodule
